// ----- sv/dts_pkg.sv -----
// shared constants, codes and types of the deadline timer scheduler
package dts_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAX_REPORTS = 16;

    localparam int ID_W      = 32;
    localparam int PERIOD_W  = 24;
    localparam int DELAY_W   = 24;
    localparam int CNT_OUT_W = 5;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 40;

    localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int COUNT_W = $clog2(NUM_TIMERS + 1);
    localparam int KCNT_W  = $clog2(MAX_REPORTS + 1);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        EV_EXPIRED   = 3'd0,
        EV_ADDED     = 3'd1,
        EV_FULL      = 3'd2,
        EV_CANCELLED = 3'd3,
        EV_NOT_FOUND = 3'd4,
        EV_CLEARED   = 3'd5
    } ev_t;

    // operands for the shared adder
    typedef struct packed {
        time_t a;
        time_t b;
        logic  sub;
    } alu_in_t;

    typedef struct packed {
        time_t sum;
        logic  expired;
        logic  better;
        logic  id_match;
    } alu_out_t;

endpackage

// ----- sv/dts_alu.sv -----
// shared adder and comparator used for every slot visit and every deadline update
module dts_alu import dts_pkg::*; (
    input  alu_in_t           op,
    input  logic [ID_W-1:0]   slot_id,
    input  time_t             best_lat,
    input  logic [ID_W-1:0]   best_id,
    input  logic [ID_W-1:0]   ref_id,
    output alu_out_t          res
);

    time_t sum;

    always_comb
    begin
        sum = op.sub ? (op.a - op.b) : (op.a + op.b);
        res.sum      = sum;
        // lateness below half the time range means the deadline has passed
        res.expired  = ~sum[TIME_BITS-1];
        res.better   = (sum > best_lat) || ((sum == best_lat) && (slot_id < best_id));
        res.id_match = (slot_id == ref_id);
    end

endmodule

// ----- sv/deadline_timer_scheduler_unit.sv -----
// top level of the deadline timer scheduler: request sequencer and timer table
//
// Timer table of NUM_TIMERS one-shot or periodic timers. One request is taken at a
// time; s_tready is high only while the block is idle. Scans and deadline updates
// use one shared adder/comparator that visits one table slot per cycle. An add or
// cancel scans slots until the first free or matching one, then updates the table
// in ST_FIRE, then offers the result in ST_OUT. A clear answers in the cycle after
// it is taken. A tick makes a full pass over all slots, then an update step, once
// for every reported timer and once more to find that none is left; a quiet tick
// gives no result. Expired timers come out earliest deadline first, each result
// carrying the active count, the last one with m_tlast set.
module deadline_timer_scheduler_unit import dts_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // delay[23:0], period[47:24], timer_id[79:48]
    input  logic [1:0]          s_tuser,  // req_type[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // timer_id_res[31:0], active_count[36:32], zero pad
    output logic [2:0]          m_tuser,  // event_res[2:0]
    output logic                m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FIRE = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                 state_reg;
    req_t                   req_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [ID_W-1:0]        tid_reg;

    time_t                  time_reg;
    logic [ID_W-1:0]        next_id_reg;
    logic [ID_W-1:0]        next_id_next;
    logic [NUM_TIMERS-1:0]  valid_reg;
    logic [NUM_TIMERS-1:0]  fired_reg;
    logic [COUNT_W-1:0]     count_reg;

    logic [ID_W-1:0]        slot_id_reg       [NUM_TIMERS];
    time_t                  slot_deadline_reg [NUM_TIMERS];
    logic [PERIOD_W-1:0]    slot_period_reg   [NUM_TIMERS];

    logic [SLOT_W-1:0]      idx_reg;
    logic                   found_reg;
    logic [SLOT_W-1:0]      best_idx_reg;
    time_t                  best_lat_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic [KCNT_W-1:0]      k_reg;

    logic                   pend_valid_reg;
    logic [ID_W-1:0]        pend_id_reg;
    logic [COUNT_W-1:0]     pend_count_reg;

    ev_t                    out_event_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_last_reg;

    logic [SLOT_W-1:0]      rd_idx;
    logic [ID_W-1:0]        rd_id;
    time_t                  rd_deadline;
    logic [PERIOD_W-1:0]    rd_period;
    alu_in_t                alu_in;
    alu_out_t               alu_res;
    logic                   take;
    logic                   scan_done;
    logic                   fire_go;
    logic [COUNT_W-1:0]     fire_count;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = out_event_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - ID_W - CNT_OUT_W){1'b0}},
                       CNT_OUT_W'(out_count_reg), out_id_reg};

    // single table read port: scan position, or the chosen slot during the update
    assign rd_idx      = (state_reg == ST_FIRE) ? best_idx_reg : idx_reg;
    assign rd_id       = slot_id_reg[rd_idx];
    assign rd_deadline = slot_deadline_reg[rd_idx];
    assign rd_period   = slot_period_reg[rd_idx];

    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            alu_in.a   = time_reg;
            alu_in.b   = rd_deadline;
            alu_in.sub = 1'b1;
        end
        else if (req_reg == REQ_TICK)
        begin
            alu_in.a   = rd_deadline;
            alu_in.b   = TIME_BITS'(rd_period);
            alu_in.sub = 1'b0;
        end
        else
        begin
            alu_in.a   = time_reg;
            alu_in.b   = TIME_BITS'(delay_reg);
            alu_in.sub = 1'b0;
        end
    end

    dts_alu u_alu (
        .op       (alu_in),
        .slot_id  (rd_id),
        .best_lat (best_lat_reg),
        .best_id  (best_id_reg),
        .ref_id   (tid_reg),
        .res      (alu_res)
    );

    always_comb
    begin
        case (req_reg)
            REQ_TICK:
                take = valid_reg[idx_reg] && !fired_reg[idx_reg] && alu_res.expired &&
                       (!found_reg || alu_res.better);
            REQ_ADD:
                take = !valid_reg[idx_reg] && !found_reg;
            REQ_CANCEL:
                take = valid_reg[idx_reg] && alu_res.id_match && !found_reg;
            default:
                take = 1'b0;
        endcase
        scan_done = (idx_reg == SLOT_W'(NUM_TIMERS - 1)) || ((req_reg != REQ_TICK) && take);
        fire_go   = found_reg && ((req_reg != REQ_TICK) || (k_reg < KCNT_W'(MAX_REPORTS)));
        // a one-shot timer leaves the table when it fires
        fire_count = (rd_period != '0) ? count_reg : (count_reg - COUNT_W'(1));
        next_id_next = next_id_reg + ID_W'(1);
        if (next_id_next == '0)
        begin
            next_id_next = ID_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= REQ_TICK;
            delay_reg      <= '0;
            period_reg     <= '0;
            tid_reg        <= '0;
            time_reg       <= '0;
            next_id_reg    <= ID_W'(1);
            valid_reg      <= '0;
            fired_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_lat_reg   <= '0;
            best_id_reg    <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            pend_count_reg <= '0;
            out_event_reg  <= EV_EXPIRED;
            out_id_reg     <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg        <= req_t'(s_tuser);
                        delay_reg      <= s_tdata[23:0];
                        period_reg     <= s_tdata[47:24];
                        tid_reg        <= s_tdata[79:48];
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        k_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        case (req_t'(s_tuser))
                            REQ_TICK:
                            begin
                                time_reg  <= time_reg + TIME_BITS'(1);
                                fired_reg <= '0;
                                state_reg <= ST_SCAN;
                            end
                            REQ_CLEAR:
                            begin
                                valid_reg     <= '0;
                                count_reg     <= '0;
                                out_event_reg <= EV_CLEARED;
                                out_id_reg    <= '0;
                                out_count_reg <= '0;
                                out_last_reg  <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                            default:
                            begin
                                state_reg <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= idx_reg;
                        best_lat_reg <= alu_res.sum;
                        best_id_reg  <= rd_id;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_FIRE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                ST_FIRE:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    case (req_reg)
                        REQ_TICK:
                        begin
                            if (fire_go)
                            begin
                                fired_reg[best_idx_reg] <= 1'b1;
                                k_reg <= k_reg + KCNT_W'(1);
                                if (rd_period == '0)
                                begin
                                    valid_reg[best_idx_reg] <= 1'b0;
                                end
                                count_reg      <= fire_count;
                                pend_valid_reg <= 1'b1;
                                pend_id_reg    <= best_id_reg;
                                pend_count_reg <= fire_count;
                                // the previous report is known not to be the last one now
                                if (pend_valid_reg)
                                begin
                                    out_event_reg <= EV_EXPIRED;
                                    out_id_reg    <= pend_id_reg;
                                    out_count_reg <= pend_count_reg;
                                    out_last_reg  <= 1'b0;
                                    state_reg     <= ST_OUT;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            else if (pend_valid_reg)
                            begin
                                pend_valid_reg <= 1'b0;
                                out_event_reg  <= EV_EXPIRED;
                                out_id_reg     <= pend_id_reg;
                                out_count_reg  <= pend_count_reg;
                                out_last_reg   <= 1'b1;
                                state_reg      <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        REQ_ADD:
                        begin
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_OUT;
                            if (found_reg)
                            begin
                                valid_reg[best_idx_reg] <= 1'b1;
                                count_reg     <= count_reg + COUNT_W'(1);
                                next_id_reg   <= next_id_next;
                                out_event_reg <= EV_ADDED;
                                out_id_reg    <= next_id_reg;
                                out_count_reg <= count_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                out_event_reg <= EV_FULL;
                                out_id_reg    <= '0;
                                out_count_reg <= count_reg;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_OUT;
                            if (found_reg)
                            begin
                                valid_reg[best_idx_reg] <= 1'b0;
                                count_reg     <= count_reg - COUNT_W'(1);
                                out_event_reg <= EV_CANCELLED;
                                out_id_reg    <= tid_reg;
                                out_count_reg <= count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                out_event_reg <= EV_NOT_FOUND;
                                out_id_reg    <= '0;
                                out_count_reg <= count_reg;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= out_last_reg ? ST_IDLE : ST_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // timer table contents
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIRE)
        begin
            if ((req_reg == REQ_ADD) && found_reg)
            begin
                slot_id_reg[best_idx_reg]       <= next_id_reg;
                slot_deadline_reg[best_idx_reg] <= alu_res.sum;
                slot_period_reg[best_idx_reg]   <= period_reg;
            end
            else if ((req_reg == REQ_TICK) && fire_go && (rd_period != '0))
            begin
                slot_deadline_reg[best_idx_reg] <= alu_res.sum;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_xor_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_W'($countones(valid_reg)))
        else $error("active count out of step with table");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("id counter reached zero");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after final result");
`endif

endmodule

// ----- tb/dts_checker.sv -----
// checker for the deadline timer scheduler: mirrors the timer table and compares every result
module dts_checker
    import dts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // delay[23:0], period[47:24], timer_id[79:48]
    input  logic [1:0]          s_tuser,  // req_type[1:0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,  // timer_id_res[31:0], active_count[36:32], zero pad
    input  logic [2:0]          m_tuser,  // event_res[2:0]
    input  logic                m_tlast,
    output int                  errors,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 50;

    typedef struct {
        ev_t                  ev;
        logic [ID_W-1:0]      id;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } timer_event_t;

    time_t                 clock_now;
    logic [ID_W-1:0]       id_counter;
    logic                  slot_live   [NUM_TIMERS];
    logic [ID_W-1:0]       slot_owner  [NUM_TIMERS];
    time_t                 slot_due    [NUM_TIMERS];
    logic [PERIOD_W-1:0]   slot_reload [NUM_TIMERS];

    timer_event_t pending_events[$];
    int mismatches = 0;
    int queued = 0;

    assign errors      = mismatches;
    assign outstanding = queued;

    task automatic report_error(string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [CNT_OUT_W-1:0] live_timers();
        int n;
        n = 0;
        for (int s = 0; s < NUM_TIMERS; s++)
            if (slot_live[s])
                n++;
        return n[CNT_OUT_W-1:0];
    endfunction

    function automatic void queue_event(ev_t ev, logic [ID_W-1:0] id, logic last);
        timer_event_t e;
        e.ev    = ev;
        e.id    = id;
        e.count = live_timers();
        e.last  = last;
        pending_events.push_back(e);
    endfunction

    function automatic void clear_model();
        clock_now  = '0;
        id_counter = 1;
        for (int s = 0; s < NUM_TIMERS; s++)
        begin
            slot_live[s]   = 1'b0;
            slot_owner[s]  = '0;
            slot_due[s]    = '0;
            slot_reload[s] = '0;
        end
        pending_events.delete();
    endfunction

    // advance time and report expired timers, most overdue first, older id on ties
    function automatic void run_tick();
        logic            fired [NUM_TIMERS];
        int              best;
        int              k;
        time_t           late;
        time_t           best_late;
        logic [ID_W-1:0] fid;
        timer_event_t    tail;
        clock_now = clock_now + time_t'(1);
        k = 0;
        for (int s = 0; s < NUM_TIMERS; s++)
            fired[s] = 1'b0;
        while (k < MAX_REPORTS)
        begin
            best = -1;
            for (int s = 0; s < NUM_TIMERS; s++)
            begin
                if (slot_live[s] && !fired[s])
                begin
                    late = clock_now - slot_due[s];
                    if (!late[TIME_BITS-1])
                    begin
                        if (best < 0)
                            best = s;
                        else
                        begin
                            best_late = clock_now - slot_due[best];
                            if (late > best_late ||
                                (late == best_late && slot_owner[s] < slot_owner[best]))
                                best = s;
                        end
                    end
                end
            end
            if (best < 0)
                break;
            fired[best] = 1'b1;
            fid = slot_owner[best];
            if (slot_reload[best] != 0)
                slot_due[best] = slot_due[best] + time_t'(slot_reload[best]);
            else
                slot_live[best] = 1'b0;
            queue_event(EV_EXPIRED, fid, 1'b0);
            k++;
        end
        if (k > 0)
        begin
            tail = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events.push_back(tail);
        end
    endfunction

    function automatic void apply_request(req_t req, logic [DELAY_W-1:0] delay,
                                          logic [PERIOD_W-1:0] period, logic [ID_W-1:0] tid);
        int slot;
        slot = -1;
        case (req)
            REQ_TICK:
                run_tick();
            REQ_ADD:
            begin
                for (int s = 0; s < NUM_TIMERS; s++)
                    if (!slot_live[s] && slot < 0)
                        slot = s;
                if (slot < 0)
                    queue_event(EV_FULL, '0, 1'b1);
                else
                begin
                    slot_live[slot]   = 1'b1;
                    slot_owner[slot]  = id_counter;
                    slot_due[slot]    = clock_now + time_t'(delay);
                    slot_reload[slot] = period;
                    queue_event(EV_ADDED, id_counter, 1'b1);
                    id_counter = id_counter + ID_W'(1);
                    if (id_counter == 0)
                        id_counter = 1;
                end
            end
            REQ_CANCEL:
            begin
                for (int s = 0; s < NUM_TIMERS; s++)
                    if (slot_live[s] && slot_owner[s] == tid && slot < 0)
                        slot = s;
                if (slot < 0)
                    queue_event(EV_NOT_FOUND, '0, 1'b1);
                else
                begin
                    slot_live[slot] = 1'b0;
                    queue_event(EV_CANCELLED, tid, 1'b1);
                end
            end
            default:
            begin
                for (int s = 0; s < NUM_TIMERS; s++)
                    slot_live[s] = 1'b0;
                queue_event(EV_CLEARED, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic check_result();
        timer_event_t want;
        if (pending_events.size() == 0)
        begin
            report_error($sformatf("result with nothing expected: event %0d id %0d",
                                   m_tuser, m_tdata[ID_W-1:0]));
            return;
        end
        want = pending_events.pop_front();
        if (m_tuser != want.ev)
            report_error($sformatf("event got %0d expected %0d", m_tuser, want.ev));
        if (m_tdata[ID_W-1:0] != want.id)
            report_error($sformatf("timer id got %0d expected %0d", m_tdata[ID_W-1:0], want.id));
        if (m_tdata[ID_W+CNT_OUT_W-1:ID_W] != want.count)
            report_error($sformatf("active count got %0d expected %0d",
                                   m_tdata[ID_W+CNT_OUT_W-1:ID_W], want.count));
        if (m_tlast != want.last)
            report_error($sformatf("last flag got %0d expected %0d", m_tlast, want.last));
    endtask

    // inputs are handled before outputs so a same-edge result would still find its entry
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (s_tvalid && s_tready)
                apply_request(req_t'(s_tuser), s_tdata[DELAY_W-1:0],
                              s_tdata[DELAY_W+PERIOD_W-1:DELAY_W],
                              s_tdata[DELAY_W+PERIOD_W+ID_W-1:DELAY_W+PERIOD_W]);
            if (m_tvalid && m_tready)
                check_result();
        end
        queued = pending_events.size();
    end

endmodule

// ----- tb/tb.sv -----
// top of the deadline timer scheduler testbench: clock, reset, request stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dts_pkg::*;

    localparam int RANDOM_ITEMS = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 500000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // delay[23:0], period[47:24], timer_id[79:48]
    logic [1:0]          s_tuser  = '0;  // req_type[1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // timer_id_res[31:0], active_count[36:32], zero pad
    logic [2:0]          m_tuser;        // event_res[2:0]
    logic                m_tlast;

    int fail_count;
    int waiting;
    int cycle_count = 0;
    int adds_sent   = 0;
    bit pace_on     = 1'b1;
    bit calm        = 1'b0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;

    deadline_timer_scheduler_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dts_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (fail_count),
        .outstanding (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one request transaction; valid stays high into the next one unless a gap is drawn
    task automatic send_request(req_t req, logic [DELAY_W-1:0] delay,
                                logic [PERIOD_W-1:0] period, logic [ID_W-1:0] tid);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {tid, period, delay};
        do @(posedge clk); while (!s_tready);
        if (req == REQ_ADD)
            adds_sent++;
        if (!calm && pace_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic random_request();
        int                  pick;
        int                  sel;
        logic [DELAY_W-1:0]  delay;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     tid;
        req_t                req;
        pick = $urandom_range(0, 99);
        // mostly short delays and periods so timers actually fire within the run
        sel = $urandom_range(0, 9);
        if (sel < 7)
            delay = DELAY_W'($urandom_range(0, 6));
        else if (sel < 9)
            delay = DELAY_W'($urandom_range(0, 40));
        else
            delay = DELAY_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 5)
            period = '0;
        else if (sel < 8)
            period = PERIOD_W'($urandom_range(1, 8));
        else
            period = PERIOD_W'($urandom);
        // cancel mostly hits ids that were handed out
        sel = $urandom_range(0, 9);
        if (sel < 7)
            tid = $urandom_range(1, adds_sent + 1);
        else if (sel < 8)
            tid = '0;
        else
            tid = $urandom;
        if (pick < 40)
            req = REQ_TICK;
        else if (pick < 75)
            req = REQ_ADD;
        else if (pick < 93)
            req = REQ_CANCEL;
        else
            req = REQ_CLEAR;
        send_request(req, delay, period, tid);
    endtask

    // receiver: random stall bursts, one long hold-off, no stalls near the end
    initial
    begin
        int mode;
        int span;
        mode = 1;
        span = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (span <= 0)
            begin
                mode = $urandom_range(0, 2);
                span = 64;
            end
            if (hold_go && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && mode != 0 && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                span--;
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
                span--;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quiet tick, unknown id zero, clear of an empty table
        send_request(REQ_TICK, '0, '0, '0);
        send_request(REQ_CANCEL, '0, '0, '0);
        send_request(REQ_CLEAR, '0, '0, '0);
        // zero delay one-shot and a period-1 timer that stays overdue after its reload
        send_request(REQ_ADD, '0, '0, '0);
        send_request(REQ_ADD, '0, 24'd1, '0);
        send_request(REQ_TICK, '0, '0, '0);
        send_request(REQ_TICK, '0, '0, '0);
        send_request(REQ_CANCEL, '0, '0, 32'd2);
        send_request(REQ_CANCEL, '0, '0, 32'd2);
        send_request(REQ_ADD, '1, '1, '1);
        send_request(REQ_CANCEL, '1, '1, '1);
        // fill the table, get refused, then fire many timers on one tick
        for (int n = 0; n < NUM_TIMERS - 1; n++)
            send_request(REQ_ADD, 24'd1, (n % 3 == 0) ? 24'd2 : 24'd0, '0);
        send_request(REQ_ADD, 24'd5, '0, '0);
        send_request(REQ_TICK, '0, '0, '0);
        send_request(REQ_CLEAR, '1, '1, '1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 16 == 0)
                pace_on = ($urandom_range(0, 2) != 0);
            if (i == 20)
                hold_go = 1'b1;
            if (i == RANDOM_ITEMS - 30)
                calm = 1'b1;
            random_request();
        end
        s_tvalid <= 1'b0;

        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
